// ----- rtl/pbf_pkg.sv -----
// Shared types and constants for the packed 2bpp frame buffer.
package pbf_pkg;

  localparam int unsigned PanelWidthDef  = 300;
  localparam int unsigned PanelHeightDef = 400;

  localparam logic [1:0] ColorHiMask = 2'h2;
  localparam logic [1:0] ColorLoMask = 2'h1;
  localparam logic [7:0] ClearByte   = 8'h00;

  typedef enum logic [1:0] {
    REQ_DRAW = 2'd0,
    REQ_READ = 2'd1,
    REQ_FILL = 2'd2
  } pbf_req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_FILL
  } pbf_state_e;

  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
  } pbf_mask_t;

endpackage

// ----- rtl/packed_2bpp_pixel_framebuffer_unit.sv -----
// Top level of the packed 2bpp frame buffer with pixel plot, fill and byte read.
//
// Input stream (s_axis): one word per request. tuser carries the request kind
// (draw pixel, read packed byte, fill memory); tdata carries the coordinates,
// colour, fill byte and read index. Output stream (m_axis): one word per
// request, tdata the packed byte of a good read (zero otherwise), tuser the
// bad-argument flag.
// Each memory byte holds a 2x2 block of 2-bit pixels; a draw mirrors both
// coordinates and rewrites two bits of one byte by read-modify-write.
// Draw, read and unused requests pass through a read step, in which in-range
// draws and reads read the frame memory (synchronous read, registered data),
// and a step that modifies, writes back and loads the result register. A fill
// sweeps the whole memory through the one-byte-per-cycle write port, then
// loads the result register. After reset the block clears every memory byte
// to ClearByte (zero) with tready low; the memory holds MEM_DEPTH bytes (30000 at the default panel size).
// The result register decouples the sides: the next request is taken while
// a result waits; a request whose result finds the register still full
// holds in place until the receiver takes the waiting word.
module packed_2bpp_pixel_framebuffer_unit #(
  parameter int unsigned PANEL_WIDTH  = pbf_pkg::PanelWidthDef,
  parameter int unsigned PANEL_HEIGHT = pbf_pkg::PanelHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // pix_x[8:0], pix_y[17:9], pix_color[19:18], fill_byte[27:20],
  // read_index[42:28], zero[47:43]
  input  logic [47:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // read_data[7:0]
  output logic [7:0]  m_axis_tdata_o,
  // bad_arg[0]
  output logic        m_axis_tuser_o
);
  import pbf_pkg::*;

  localparam int unsigned DataWidth  = (PANEL_WIDTH + 1) / 2;
  localparam int unsigned DataHeight = (PANEL_HEIGHT + 1) / 2;
  localparam int unsigned MemDepth   = DataWidth * DataHeight;
  localparam int unsigned AddrW      = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  logic [AddrW-1:0] addr;
  logic             bad;
  pbf_mask_t        mask;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  pbf_addr #(
    .PanelWidth  (PANEL_WIDTH),
    .PanelHeight (PANEL_HEIGHT),
    .AddrW       (AddrW)
  ) u_addr (
    .req_type_i   (s_axis_tuser_i),
    .pix_x_i      (s_axis_tdata_i[8:0]),
    .pix_y_i      (s_axis_tdata_i[17:9]),
    .read_index_i (s_axis_tdata_i[42:28]),
    .addr_o       (addr),
    .bad_o        (bad),
    .mask_o       (mask)
  );

  pbf_ctrl #(
    .MemDepth (MemDepth),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .pix_color_i (s_axis_tdata_i[19:18]),
    .fill_byte_i (s_axis_tdata_i[27:20]),
    .addr_i      (addr),
    .bad_i       (bad),
    .mask_i      (mask),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .read_data_o (m_axis_tdata_o),
    .bad_arg_o   (m_axis_tuser_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pbf_mem #(
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- rtl/pbf_mem.sv -----
// Frame byte memory: one write port, one read port with registered read data.
module pbf_mem #(
  parameter int unsigned Depth = 30000,
  parameter int unsigned AddrW = 15
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pbf_addr.sv -----
// Range check, coordinate mirroring, byte index and bit masks for a request.
module pbf_addr #(
  parameter int unsigned PanelWidth  = 300,
  parameter int unsigned PanelHeight = 400,
  parameter int unsigned AddrW       = 15
) (
  input  logic [1:0]           req_type_i,
  input  logic [8:0]           pix_x_i,
  input  logic [8:0]           pix_y_i,
  input  logic [14:0]          read_index_i,
  output logic [AddrW-1:0]     addr_o,
  output logic                 bad_o,
  output pbf_pkg::pbf_mask_t   mask_o
);
  import pbf_pkg::*;

  localparam int unsigned DataWidth  = (PanelWidth + 1) / 2;
  localparam int unsigned DataHeight = (PanelHeight + 1) / 2;
  localparam int unsigned MemDepth   = DataWidth * DataHeight;

  localparam logic [9:0]  WidthC  = 10'(PanelWidth);
  localparam logic [9:0]  HeightC = 10'(PanelHeight);
  localparam logic [16:0] RowC    = 17'(DataWidth);
  localparam logic [16:0] DepthC  = 17'(MemDepth);

  logic        in_panel;
  logic [9:0]  mx_full;
  logic [9:0]  my_full;
  logic [8:0]  mx;
  logic [8:0]  my;
  logic [16:0] row_base;
  logic [16:0] draw_idx;
  logic [16:0] read_idx;
  logic [16:0] sel_idx;
  logic [2:0]  pos_hi;
  logic [2:0]  pos_lo;

  always_comb begin
    in_panel = ({1'b0, pix_x_i} < WidthC) && ({1'b0, pix_y_i} < HeightC);
    mx_full  = WidthC - 10'd1 - {1'b0, pix_x_i};
    my_full  = HeightC - 10'd1 - {1'b0, pix_y_i};
    mx       = mx_full[8:0];
    my       = my_full[8:0];
    row_base = 17'(my[8:1]) * RowC;
    draw_idx = row_base + 17'(mx[8:1]);
    read_idx = {2'b00, read_index_i};
    pos_hi   = {~mx[0], 1'b1, ~my[0]};
    pos_lo   = {~mx[0], 1'b0, ~my[0]};
    mask_o.hi = 8'h01 << pos_hi;
    mask_o.lo = 8'h01 << pos_lo;

    case (req_type_i)
      REQ_DRAW: begin
        sel_idx = draw_idx;
        bad_o   = !in_panel || (draw_idx >= DepthC);
      end
      REQ_READ: begin
        sel_idx = read_idx;
        bad_o   = read_idx >= DepthC;
      end
      default: begin
        sel_idx = read_idx;
        bad_o   = 1'b0;
      end
    endcase
    addr_o = sel_idx[AddrW-1:0];
  end

endmodule

// ----- rtl/pbf_ctrl.sv -----
// Request sequencer: clear and fill sweeps, read-modify-write, result register.
module pbf_ctrl #(
  parameter int unsigned MemDepth = 30000,
  parameter int unsigned AddrW    = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [1:0]         pix_color_i,
  input  logic [7:0]         fill_byte_i,
  input  logic [AddrW-1:0]   addr_i,
  input  logic               bad_i,
  input  pbf_pkg::pbf_mask_t mask_i,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [7:0]         read_data_o,
  output logic               bad_arg_o,
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_waddr_o,
  output logic [7:0]         mem_wdata_o,
  output logic               mem_re_o,
  output logic [AddrW-1:0]   mem_raddr_o,
  input  logic [7:0]         mem_rdata_i
);
  import pbf_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(MemDepth - 1);

  pbf_state_e state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_data_q, out_data_d;
  logic             out_bad_q, out_bad_d;
  logic [1:0]       req_q;
  logic             bad_q;
  logic [AddrW-1:0] addr_q;
  pbf_mask_t        mask_q;
  logic [1:0]       color_q;
  logic [7:0]       fill_q;

  logic accept;
  logic sweep_last;
  logic resp_done;
  logic [7:0] mod_byte;

  assign s_ready_o  = (state_q == ST_IDLE);
  assign accept     = s_valid_i && s_ready_o;
  assign sweep_last = (cnt_q == LastAddr);
  assign resp_done  = (state_q == ST_RESP) && (!out_vld_q || m_ready_i);

  always_comb begin
    mod_byte = mem_rdata_i & ~(mask_q.hi | mask_q.lo);
    if ((color_q & ColorHiMask) != 2'b00) begin
      mod_byte = mod_byte | mask_q.hi;
    end
    if ((color_q & ColorLoMask) != 2'b00) begin
      mod_byte = mod_byte | mask_q.lo;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_type_i == REQ_FILL) ? ST_FILL : ST_RESP;
        end
      end
      ST_FILL: begin
        if (sweep_last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (resp_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = fill_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_i;
    out_vld_d   = out_vld_q && !m_ready_i;
    out_data_d  = out_data_q;
    out_bad_d   = out_bad_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = ClearByte;
        cnt_d       = cnt_q + AddrW'(1);
      end
      ST_IDLE: begin
        cnt_d = '0;
        mem_re_o = accept && !bad_i &&
                   ((req_type_i == REQ_DRAW) || (req_type_i == REQ_READ));
      end
      ST_FILL: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + AddrW'(1);
      end
      ST_RESP: begin
        if (resp_done) begin
          mem_we_o    = (req_q == REQ_DRAW) && !bad_q;
          mem_waddr_o = addr_q;
          mem_wdata_o = mod_byte;
          out_vld_d   = 1'b1;
          out_bad_d   = bad_q;
          out_data_d  = ((req_q == REQ_READ) && !bad_q) ? mem_rdata_i : 8'h00;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_bad_q  <= out_bad_d;
    if (accept) begin
      req_q   <= req_type_i;
      bad_q   <= bad_i;
      addr_q  <= addr_i;
      mask_q  <= mask_i;
      color_q <= pix_color_i;
      fill_q  <= fill_byte_i;
    end
  end

  assign m_valid_o   = out_vld_q;
  assign read_data_o = out_data_q;
  assign bad_arg_o   = out_bad_q;

endmodule

// ----- rtl/pbf_checker.sv -----
// Port-level checks for the packed 2bpp frame buffer, bound to the top level.
module pbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  a_bad_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("bad-argument result carries nonzero data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while previous request still in work");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a request in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output word changed");

endmodule

bind packed_2bpp_pixel_framebuffer_unit pbf_checker u_pbf_checker (.*);
